[design/pt64_pkg.sv]
package pt64_pkg;

  localparam int W = 63;
  localparam int MAX_BASES = 12;
  localparam int IDX_W = 4;
  localparam int SW = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_STRIP,
    ST_BASE,
    ST_POW,
    ST_POW_WAIT,
    ST_CHECK0,
    ST_SQ_WAIT,
    ST_CHECKJ,
    ST_PASS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic strip;
    logic base_init;
    logic mul_start;
    logic sq_mode;
    logic pow_update;
    logic sq_update;
    logic base_next;
    logic set_result;
    logic result_val;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic d_even;
    logic n_eq_b;
    logic n_lt_b;
    logic e_zero;
    logic mul_done;
    logic x_one;
    logic x_nm1;
    logic s_zero;
    logic cnt_gt1;
    logic last_base;
  } status_t;

  function automatic logic [W-1:0] base_at(input logic [IDX_W-1:0] i);
    logic [W-1:0] b;
    case (i)
      4'd0:    b = W'(2);
      4'd1:    b = W'(3);
      4'd2:    b = W'(5);
      4'd3:    b = W'(7);
      4'd4:    b = W'(11);
      4'd5:    b = W'(13);
      4'd6:    b = W'(17);
      4'd7:    b = W'(19);
      4'd8:    b = W'(23);
      4'd9:    b = W'(29);
      4'd10:   b = W'(31);
      4'd11:   b = W'(37);
      default: b = W'(37);
    endcase
    return b;
  endfunction

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    logic [W:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, m};
    return (s >= {1'b0, m}) ? t[W-1:0] : s[W-1:0];
  endfunction

endpackage

[design/pt64_mulmod.sv]
module pt64_mulmod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [pt64_pkg::W-1:0] a,
  input  logic [pt64_pkg::W-1:0] b,
  input  logic [pt64_pkg::W-1:0] m,
  output logic [pt64_pkg::W-1:0] prod,
  output logic                 done
);
  import pt64_pkg::*;

  logic          busy;
  logic [SW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  aa;
  logic [W-1:0]  bb;
  logic [W-1:0]  mreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // add-and-double over the multiplier bits
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      aa   <= a;
      bb   <= b;
      mreg <= m;
    end else if (busy) begin
      if (bb[0]) acc <= add_mod(acc, aa, mreg);
      aa <= add_mod(aa, aa, mreg);
      bb <= bb >> 1;
    end
  end

  assign prod = acc;

endmodule

[design/pt64_datapath.sv]
module pt64_datapath #(
  parameter int NB = 9
) (
  input  logic                   clk,
  input  logic [pt64_pkg::W-1:0] candidate,
  input  logic                   rst,
  input  pt64_pkg::cmd_t         cmd,
  output pt64_pkg::status_t      status,
  output logic                   is_prime
);
  import pt64_pkg::*;

  logic [W-1:0]     n;
  logic [W-1:0]     d;
  logic [SW-1:0]    s;
  logic [IDX_W-1:0] idx;
  logic [W-1:0]     acc;
  logic [W-1:0]     bb;
  logic [W-1:0]     e;
  logic [SW-1:0]    cnt;
  logic [W-1:0]     base;
  logic [W-1:0]     nm1;
  logic [W-1:0]     a_in;
  logic [W-1:0]     b_in;
  logic [W-1:0]     prod_a;
  logic [W-1:0]     prod_b;
  logic             done_a;
  logic             done_b;

  assign base = base_at(idx);
  assign nm1  = n - W'(1);
  assign a_in = acc;
  assign b_in = cmd.sq_mode ? acc : bb;

  pt64_mulmod u_mul_a (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(a_in), .b(b_in), .m(n),
    .prod(prod_a), .done(done_a)
  );

  pt64_mulmod u_mul_b (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(bb), .b(bb), .m(n),
    .prod(prod_b), .done(done_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= candidate;
      d   <= candidate - W'(1);
      s   <= '0;
      idx <= '0;
    end
    if (cmd.strip) begin
      d <= d >> 1;
      s <= s + 1'b1;
    end
    if (cmd.base_init) begin
      acc <= W'(1);
      bb  <= base;
      e   <= d;
      cnt <= s;
    end
    if (cmd.mul_start && cmd.sq_mode) cnt <= cnt - 1'b1;
    if (cmd.pow_update) begin
      if (e[0]) acc <= prod_a;
      bb <= prod_b;
      e  <= e >> 1;
    end
    if (cmd.sq_update) acc <= prod_a;
    if (cmd.base_next) idx <= idx + 1'b1;
    if (cmd.set_result) is_prime <= cmd.result_val;
  end

  always_comb begin
    status.n_lt2     = (n < W'(2));
    status.d_even    = ~d[0];
    status.n_eq_b    = (n == base);
    status.n_lt_b    = (n < base);
    status.e_zero    = (e == '0);
    status.mul_done  = done_a & done_b;
    status.x_one     = (acc == W'(1));
    status.x_nm1     = (acc == nm1);
    status.s_zero    = (s == '0);
    status.cnt_gt1   = (cnt > SW'(1));
    status.last_base = (idx == IDX_W'(NB - 1));
  end

endmodule

[design/pt64_ctrl.sv]
module pt64_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_stall,
  input  pt64_pkg::status_t status,
  output pt64_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import pt64_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_PREP;
      ST_PREP:     state_next = status.n_lt2 ? ST_DONE : ST_STRIP;
      ST_STRIP:    if (!status.d_even) state_next = ST_BASE;
      ST_BASE: begin
        if (status.n_eq_b || status.n_lt_b) state_next = ST_DONE;
        else                                 state_next = ST_POW;
      end
      ST_POW:      state_next = status.e_zero ? ST_CHECK0 : ST_POW_WAIT;
      ST_POW_WAIT: if (status.mul_done) state_next = ST_POW;
      ST_CHECK0: begin
        if (status.x_one || (status.x_nm1 && !status.s_zero)) state_next = ST_PASS;
        else if (status.cnt_gt1)                              state_next = ST_SQ_WAIT;
        else                                                  state_next = ST_DONE;
      end
      ST_SQ_WAIT:  if (status.mul_done) state_next = ST_CHECKJ;
      ST_CHECKJ: begin
        if (status.x_nm1)        state_next = ST_PASS;
        else if (status.cnt_gt1) state_next = ST_SQ_WAIT;
        else                     state_next = ST_DONE;
      end
      ST_PASS:     state_next = status.last_base ? ST_DONE : ST_BASE;
      ST_DONE:     if (!out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    unique case (state)
      ST_IDLE:     cmd.load = in_valid;
      ST_PREP: begin
        if (status.n_lt2) begin
          cmd.set_result = 1'b1;
          cmd.result_val = 1'b0;
        end
      end
      ST_STRIP:    cmd.strip = status.d_even;
      ST_BASE: begin
        if (status.n_eq_b || status.n_lt_b) begin
          cmd.set_result = 1'b1;
          cmd.result_val = status.n_eq_b;
        end else begin
          cmd.base_init = 1'b1;
        end
      end
      ST_POW:      cmd.mul_start = ~status.e_zero;
      ST_POW_WAIT: cmd.pow_update = status.mul_done;
      ST_CHECK0: begin
        if (status.x_one || (status.x_nm1 && !status.s_zero)) begin
          cmd = '0;
        end else if (status.cnt_gt1) begin
          cmd.mul_start = 1'b1;
          cmd.sq_mode   = 1'b1;
        end else begin
          cmd.set_result = 1'b1;
        end
      end
      ST_SQ_WAIT:  cmd.sq_update = status.mul_done;
      ST_CHECKJ: begin
        if (status.x_nm1) begin
          cmd = '0;
        end else if (status.cnt_gt1) begin
          cmd.mul_start = 1'b1;
          cmd.sq_mode   = 1'b1;
        end else begin
          cmd.set_result = 1'b1;
        end
      end
      ST_PASS: begin
        if (status.last_base) begin
          cmd.set_result = 1'b1;
          cmd.result_val = 1'b1;
        end else begin
          cmd.base_next = 1'b1;
        end
      end
      ST_DONE:     cmd = '0;
      default:     cmd = '0;
    endcase
  end

endmodule

[design/primality_test_64.sv]
// Deterministic strong-probable-prime test of one 63-bit unsigned candidate per word, answering
// 1 for prime; exact below 3.8e18 with the default nine bases 2 through 23. One candidate is
// processed at a time. Time per candidate is set by two shift-and-add modular multipliers
// working in parallel: per base, one multiplication per bit of the odd part of n-1 (up to 63
// bits) plus one squaring per step (up to one less than the count of trailing zeros of n-1);
// 0 and 1 finish without any multiplication.
module primality_test_64 #(
  parameter int NUM_BASES = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [pt64_pkg::W-1:0] candidate,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   is_prime
);
  import pt64_pkg::*;

  localparam int NB = (NUM_BASES > MAX_BASES) ? MAX_BASES : NUM_BASES;

  cmd_t    cmd;
  status_t status;

  pt64_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd), .in_stall(in_stall), .out_valid(out_valid)
  );

  pt64_datapath #(.NB(NB)) u_dp (
    .clk(clk), .candidate(candidate), .rst(rst), .cmd(cmd), .status(status),
    .is_prime(is_prime)
  );

`ifndef SYNTHESIS
  a_busy_when_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result right after accept");
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
`endif

endmodule
